[src/rmvs_pkg.sv]
`default_nettype none
package rmvs_pkg;
    typedef struct packed {
        logic [31:0] count;
        logic [63:0] sum;
        logic [31:0] min_v;
        logic [31:0] max_v;
        logic [47:0] mean;
        logic [63:0] m2;
        logic [47:0] std_v;
        logic        dropped;
    } t_result;
endpackage
`default_nettype wire

[src/rmvs_front.sv]
`default_nettype none
module rmvs_front #(
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_sample,
    output logic             o_q_valid,
    input  wire logic        i_q_ready,
    output logic [31:0]      o_q_sample
);
    // two-entry queue of sign-extended samples
    logic [31:0] r_mem [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic [31:0] ext;
    logic        push, pop;

    always_comb begin
        ext = 32'($signed(i_sample[SAMPLE_BITS-1:0]));
    end

    assign o_ready    = (r_cnt != 2'd2);
    assign push       = i_valid && o_ready;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign pop        = o_q_valid && i_q_ready;
    assign o_q_sample = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= ext;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

[src/rmvs_back.sv]
`default_nettype none
module rmvs_back #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_sample,
    output logic             o_valid,
    input  wire logic        i_ready,
    output rmvs_pkg::t_result o_res
);
    import rmvs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MDIV, S_MFIN, S_D1, S_D2, S_MUL, S_M2, S_SDIV, S_SQRT, S_OUT
    } t_state;

    t_state       r_state;
    logic [31:0]  r_x;
    logic [31:0]  r_count;
    logic [63:0]  r_sum;
    logic [31:0]  r_min, r_max;
    logic [47:0]  r_mean;
    logic [63:0]  r_m2;
    logic [47:0]  r_std;
    logic         r_drop;
    logic [64:0]  r_d1, r_d2;
    logic [127:0] r_prod;
    logic [1:0]   r_pstep;
    logic [127:0] r_quo;
    logic [63:0]  r_rem;
    logic [7:0]   r_bit;
    logic         r_neg;
    logic [127:0] r_rad;
    logic [49:0]  r_root;
    logic [51:0]  r_srem;

    logic [64:0]  xs;
    logic [64:0]  rem_sh;
    logic         rem_ge;
    logic [64:0]  rem_sub;
    logic [63:0]  mag;
    logic [127:0] mnum;
    logic [127:0] q_mag;
    logic [48:0]  mean_full;
    logic [51:0]  sr_shift;
    logic [51:0]  sr_try;
    logic [64:0]  m2_sum;
    logic [127:0] inc_w;
    logic [63:0]  inc_v;
    logic         inc_over;
    logic [63:0]  pp;

    always_comb begin
        xs      = 65'($signed(r_x)) <<< FRAC_BITS;
        mag     = r_sum[63] ? (64'd0 - r_sum) : r_sum;
        mnum    = {64'd0, mag} << FRAC_BITS;
        rem_sh  = {r_rem, r_quo[127]};
        rem_ge  = rem_sh >= {33'd0, r_count};
        rem_sub = rem_sh - {33'd0, r_count};
        q_mag   = r_quo;
        if (r_neg) begin
            mean_full = (q_mag > 128'h8000_0000_0000) ? 49'h1_8000_0000_0000
                : 49'(128'd0 - q_mag);
        end else begin
            mean_full = (q_mag > 128'h7FFF_FFFF_FFFF) ? 49'h0_7FFF_FFFF_FFFF
                : 49'(q_mag);
        end
        sr_shift = {r_srem[49:0], r_rad[127:126]};
        sr_try   = {r_root, 2'b01};
        inc_w    = r_prod >> FRAC_BITS;
        inc_over = inc_w[127:64] != 64'd0;
        inc_v    = inc_w[63:0];
        m2_sum   = {1'b0, r_m2} + {1'b0, inc_v};
        case (r_pstep)
            2'd0: pp = 64'(r_d1[31:0]) * 64'(r_d2[31:0]);
            2'd1: pp = 64'(r_d1[31:0]) * 64'(r_d2[63:32]);
            2'd2: pp = 64'(r_d1[63:32]) * 64'(r_d2[31:0]);
            default: pp = 64'(r_d1[63:32]) * 64'(r_d2[63:32]);
        endcase
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_res   = '{count: r_count, sum: r_sum, min_v: r_min, max_v: r_max,
                       mean: r_mean, m2: r_m2, std_v: r_std, dropped: r_drop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_sum   <= '0;
            r_min   <= '0;
            r_max   <= '0;
            r_mean  <= '0;
            r_m2    <= '0;
        end else begin
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_x <= i_sample;
                    if (r_count == 32'hFFFF_FFFF) begin
                        r_drop  <= 1'b1;
                        r_quo   <= {r_m2, 64'd0} >> (64 - FRAC_BITS);
                        r_rem   <= '0;
                        r_bit   <= 8'd128;
                        r_state <= S_SDIV;
                    end else begin
                        r_drop  <= 1'b0;
                        r_count <= r_count + 32'd1;
                        if (r_count == 32'd0) begin
                            r_sum <= 64'($signed(i_sample));
                            r_min <= i_sample;
                            r_max <= i_sample;
                            r_m2  <= '0;
                            r_d1  <= '0;
                        end else begin
                            r_sum <= r_sum + 64'($signed(i_sample));
                            if ($signed(i_sample) < $signed(r_min)) r_min <= i_sample;
                            if ($signed(i_sample) > $signed(r_max)) r_max <= i_sample;
                            r_d1 <= (65'($signed(i_sample)) <<< FRAC_BITS)
                                - 65'($signed(r_mean));
                        end
                        r_state <= S_MFIN;
                    end
                end
                S_MFIN: begin
                    r_neg   <= r_sum[63];
                    r_quo   <= mnum;
                    r_rem   <= '0;
                    r_bit   <= 8'd128;
                    r_state <= S_MDIV;
                end
                S_MDIV, S_SDIV: begin
                    // restoring divide, one quotient bit per cycle
                    r_quo <= {r_quo[126:0], rem_ge};
                    r_rem <= rem_ge ? rem_sub[63:0] : rem_sh[63:0];
                    r_bit <= (r_bit == 8'd1 && r_state == S_SDIV) ? 8'd64 : r_bit - 8'd1;
                    if (r_bit == 8'd1) begin
                        r_state <= (r_state == S_MDIV) ? S_D1 : S_SQRT;
                        if (r_state == S_SDIV) begin
                            r_rad  <= {r_quo[126:0], rem_ge};
                            r_root <= '0;
                            r_srem <= '0;
                        end
                    end
                end
                S_D1: begin
                    r_mean  <= mean_full[47:0];
                    r_d2    <= xs - 65'($signed(mean_full));
                    r_state <= S_D2;
                end
                S_D2: begin
                    if (r_count == 32'd1 || r_d1 == 65'd0 || r_d2 == 65'd0
                        || (r_d1[64] != r_d2[64])) begin
                        r_prod <= '0;
                    end else begin
                        r_d1 <= r_d1[64] ? (65'd0 - r_d1) : r_d1;
                        r_d2 <= r_d2[64] ? (65'd0 - r_d2) : r_d2;
                        r_prod <= '0;
                    end
                    r_pstep <= 2'd0;
                    r_state <= (r_count == 32'd1 || r_d1 == 65'd0 || r_d2 == 65'd0
                        || (r_d1[64] != r_d2[64])) ? S_M2 : S_MUL;
                end
                S_MUL: begin
                    case (r_pstep)
                        2'd0: r_prod <= r_prod + {64'd0, pp};
                        2'd1, 2'd2: r_prod <= r_prod + ({64'd0, pp} << 32);
                        default: r_prod <= r_prod + ({64'd0, pp} << 64);
                    endcase
                    r_pstep <= r_pstep + 2'd1;
                    if (r_pstep == 2'd3) r_state <= S_M2;
                end
                S_M2: begin
                    if (inc_over || m2_sum[64]) begin
                        r_m2 <= '1;
                        r_quo <= {64'hFFFF_FFFF_FFFF_FFFF, 64'd0} >> (64 - FRAC_BITS);
                    end else begin
                        r_m2 <= m2_sum[63:0];
                        r_quo <= {m2_sum[63:0], 64'd0} >> (64 - FRAC_BITS);
                    end
                    r_rem   <= '0;
                    r_bit   <= 8'd128;
                    r_state <= S_SDIV;
                end
                S_SQRT: begin
                    // digit-by-digit root, two radicand bits per cycle
                    r_rad <= {r_rad[125:0], 2'b00};
                    if (sr_shift >= sr_try) begin
                        r_srem <= sr_shift - sr_try;
                        r_root <= {r_root[48:0], 1'b1};
                    end else begin
                        r_srem <= sr_shift;
                        r_root <= {r_root[48:0], 1'b0};
                    end
                    r_bit <= r_bit - 8'd1;
                    if (r_bit == 8'd1) begin
                        r_std   <= {r_root[46:0], sr_shift >= sr_try};
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[src/running_mean_variance_stats.sv]
`default_nettype none
// Running count, sum, min, max, mean and Welford M2 of signed samples, with population
// standard deviation. A two-word input queue feeds a sequential datapath: one restoring
// 128-bit divide for the mean, a 4-step 32x32 multiply for M2, a 128-bit divide of M2 by
// the count and a 64-step square root, one sample at a time. Once the count saturates,
// samples are reported unchanged with sample_dropped set.
module running_mean_variance_stats #(
    parameter int SAMPLE_BITS = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_sample,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_sample_count,
    output logic [63:0]      o_running_sum,
    output logic [31:0]      o_minimum,
    output logic [31:0]      o_maximum,
    output logic [47:0]      o_mean,
    output logic [63:0]      o_squared_deviation_sum,
    output logic [47:0]      o_std_deviation,
    output logic             o_sample_dropped
);
    import rmvs_pkg::*;

    logic        q_valid, q_ready;
    logic [31:0] q_sample;
    t_result     res;
    logic [31:0] r_res_s;

    rmvs_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_sample,
        .o_q_valid(q_valid), .i_q_ready(q_ready), .o_q_sample(q_sample)
    );

    rmvs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .o_ready(q_ready), .i_sample(q_sample),
        .o_valid, .i_ready, .o_res(res)
    );

    assign o_sample_count          = res.count;
    assign o_running_sum           = res.sum;
    assign o_minimum               = res.min_v;
    assign o_maximum               = res.max_v;
    assign o_mean                  = res.mean;
    assign o_squared_deviation_sum = res.m2;
    assign o_std_deviation         = res.std_v;
    assign o_sample_dropped        = res.dropped;

    always_ff @(posedge i_clk) begin
        r_res_s <= res.count;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_std_deviation)) else $error("result moved");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_sample_dropped |-> $signed(o_minimum) <= $signed(o_maximum))
        else $error("min above max");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_sample_count != 32'd0) else $error("zero count");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_valid) && o_valid && !$past(i_ready) |-> r_res_s == o_sample_count)
        else $error("count moved");
endmodule
`default_nettype wire

[bench/tb_running_mean_variance_stats.sv]
`default_nettype none
module tb_running_mean_variance_stats;
    import rmvs_pkg::*;

    localparam int FRAC_BITS_TB = 16;
    localparam int RANDOM_ITEMS = 1700;
    localparam int PEND_DEPTH   = 256;

    class stats_scoreboard;
        logic [31:0]        count_q;
        logic signed [63:0] sum_q;
        logic signed [31:0] min_q;
        logic signed [31:0] max_q;
        logic signed [47:0] mean_q;
        logic [63:0]        m2_q;
        t_result            pending_mem[PEND_DEPTH];
        int                 wr_idx;
        int                 rd_idx;
        int                 errors;
        int                 checked;
        int                 m2_saturations;

        function new();
            count_q = 0; sum_q = 0; min_q = 0; max_q = 0; mean_q = 0; m2_q = 0;
            wr_idx = 0; rd_idx = 0;
            errors = 0; checked = 0; m2_saturations = 0;
        endfunction

        function int pending_count();
            return wr_idx - rd_idx;
        endfunction

        function logic signed [47:0] mean_of(logic signed [63:0] s, logic [31:0] n);
            logic [127:0] mag;
            logic [127:0] m;
            mag = s < 0 ? 128'd0 - 128'(s) : 128'(s);
            m = (mag << FRAC_BITS_TB) / n;
            if (s < 0)
                return m > (128'd1 << 47) ? 48'sh8000_0000_0000 : 48'(128'd0 - m);
            return m > 128'h7FFF_FFFF_FFFF ? 48'sh7FFF_FFFF_FFFF : 48'(m);
        endfunction

        function logic [47:0] std_of(logic [63:0] m2, logic [31:0] n);
            logic [127:0] q;
            logic [127:0] cand;
            logic [47:0]  r;
            r = 0;
            if (n == 0)
                return 0;
            q = ({64'd0, m2} << FRAC_BITS_TB) / n;
            for (int i = 47; i >= 0; i--) begin
                cand = 128'(r | (48'd1 << i));
                if (cand * cand <= q)
                    r = cand[47:0];
            end
            return r;
        endfunction

        function void note_sample(logic [31:0] raw);
            logic signed [31:0]  x;
            logic signed [63:0]  xs;
            logic signed [63:0]  d1;
            logic signed [63:0]  d2;
            logic [127:0]        p;
            logic [64:0]         acc;
            t_result             r;
            logic                dropped;
            x = raw;
            dropped = 0;
            if (count_q == 32'hFFFF_FFFF) begin
                dropped = 1;
            end else if (count_q == 0) begin
                count_q = 1;
                sum_q = x; min_q = x; max_q = x;
                mean_q = mean_of(64'(x), 32'd1);
                m2_q = 0;
            end else begin
                xs = 64'(x) <<< FRAC_BITS_TB;
                count_q++;
                sum_q += 64'(x);
                if (x < min_q) min_q = x;
                if (x > max_q) max_q = x;
                d1 = xs - 64'(mean_q);
                mean_q = mean_of(sum_q, count_q);
                d2 = xs - 64'(mean_q);
                if (d1 != 0 && d2 != 0 && ((d1 < 0) == (d2 < 0))) begin
                    p = 128'(d1 < 0 ? -d1 : d1) * 128'(d2 < 0 ? -d2 : d2);
                    acc = 65'(m2_q) + 65'(p[127:0] >> FRAC_BITS_TB);
                    if ((p >> (64 + FRAC_BITS_TB)) != 0 || acc[64]) begin
                        m2_q = '1;
                        m2_saturations++;
                    end else begin
                        m2_q = acc[63:0];
                    end
                end
            end
            r.count = count_q;
            r.sum = sum_q;
            r.min_v = min_q;
            r.max_v = max_q;
            r.mean = mean_q;
            r.m2 = m2_q;
            r.std_v = std_of(m2_q, count_q);
            r.dropped = dropped;
            pending_mem[wr_idx % PEND_DEPTH] = r;
            wr_idx++;
        endfunction

        function void field_check(string name, logic [63:0] e, logic [63:0] a);
            if (e !== a) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
            end
        endfunction

        function void check_result(t_result a);
            t_result e;
            checked++;
            if (pending_count() == 0) begin
                errors++;
                $display("%0t: unexpected word, actual count %0d", $time, a.count);
                return;
            end
            e = pending_mem[rd_idx % PEND_DEPTH];
            rd_idx++;
            field_check("sample_count", e.count, a.count);
            field_check("running_sum", e.sum, a.sum);
            field_check("minimum", e.min_v, a.min_v);
            field_check("maximum", e.max_v, a.max_v);
            field_check("mean", e.mean, a.mean);
            field_check("squared_deviation_sum", e.m2, a.m2);
            field_check("std_deviation", e.std_v, a.std_v);
            field_check("sample_dropped", e.dropped, a.dropped);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_sample;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_sample_count;
    logic [63:0] o_running_sum;
    logic [31:0] o_minimum;
    logic [31:0] o_maximum;
    logic [47:0] o_mean;
    logic [63:0] o_squared_deviation_sum;
    logic [47:0] o_std_deviation;
    logic        o_sample_dropped;

    stats_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int sent;

    running_mean_variance_stats DUT (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #400_000_000;
        $display("timeout");
        $display("Simulation FAILED");
        $finish;
    end

    // receiver: check on handshake, then pick ready for next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result('{o_sample_count, o_running_sum, o_minimum, o_maximum, o_mean,
                              o_squared_deviation_sum, o_std_deviation, o_sample_dropped});
        if (i_rst_n)
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_word(logic [31:0] v);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_valid <= 1;
        i_sample <= v;
        do @(posedge i_clk); while (!o_ready);
        sb.note_sample(v);
        sent++;
    endtask

    task automatic drain_results();
        while (sb.pending_count() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] random_sample();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60) return 32'($signed($urandom_range(2000)) - 1000);
        if (sel < 90) return 32'($signed($urandom_range(2_000_000)) - 1_000_000);
        return {{12{1'($urandom_range(1))}}, 20'($urandom)};
    endfunction

    initial begin
        logic [31:0] directed[$];
        sb = new();
        sent = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_ready = 0;
        i_sample = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // first word sets everything, a word equal to the mean adds nothing to m2
        directed = '{32'd0, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'd7, 32'hFFFF_FFF9,
                     32'd3, 32'd3, 32'd3, 32'h0001_0000, 32'hFFFF_0000,
                     32'h5555_5555 >> 12, 32'hAAAA_AAAA | 32'hFFF0_0000, 32'd2};
        foreach (directed[k]) send_word(directed[k]);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = ph == 0 ? 7 : (ph == 1 ? 50 : 0);
            recv_idle_pct = ph == 0 ? 50 : (ph == 1 ? 7 : 0);
            for (int k = 0; k < RANDOM_ITEMS / 3; k++) begin
                send_word(random_sample());
                if (ph == 0 && k == 100) begin
                    i_valid <= 0;
                    drain_results();
                end
            end
        end

        // full-range extremes, then random words: the extremes drive m2 into saturation
        send_idle_pct = 7;
        recv_idle_pct = 30;
        send_word(32'h7FFF_FFFF);
        send_word(32'h8000_0000);
        send_word(32'h7FFF_FFFF);
        send_word(32'h8000_0000);
        for (int k = 0; k < 40; k++) send_word($urandom);
        i_valid <= 0;

        drain_results();
        repeat (800) @(posedge i_clk);
        $display("sent %0d words, checked %0d results, m2 saturated %0d times",
                 sent, sb.checked, sb.m2_saturations);
        $display("covered signed extremes, repeated values and three stall patterns");
        if (sb.errors == 0 && sb.pending_count() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire

[running_mean_variance_stats.f]
src/rmvs_pkg.sv
src/rmvs_front.sv
src/rmvs_back.sv
src/running_mean_variance_stats.sv
bench/tb_running_mean_variance_stats.sv
